FILE: rtl/core/frpa_pkg.sv
// Shared types and constants for the free region page frame allocator.
package frpa_pkg;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam logic [63:0] PAGE_BYTES = 64'd1 << PAGE_SHIFT;
  localparam int unsigned PAGE_CNT_W = 7;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_MISALIGNED = 2'd2,
    ST_NO_MEMORY  = 2'd3
  } status_t;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_MAP = 1'b1
  } op_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] size;
  } region_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] y;
    logic        borrow;
  } alu_rsp_t;

endpackage

FILE: rtl/core/free_region_page_frame_allocator_unit.sv
// Page frame allocator: sorted free region table, page mapping sequencer.
//
// Input channel s_axis: one beat per command. tuser is the op (add region or
// map range), tdata packs region_base, region_length, virtual_base,
// page_count and map_flags. The block takes one command at a time and holds
// s_axis_tready low until the command has issued all of its result beats.
// Output channel m_axis: one beat per mapped page; a command that maps no page
// or fails ends in a single status beat; tlast marks a command's final beat.
// Sequencing: all arithmetic goes through one 64-bit add/subtract unit, one
// operation per cycle, and the region table is a RAM with one registered read
// port. An add walks from the end of the table toward its start, shifting each
// entry with a lower base down one slot before writing the new region. A map
// checks the free total, then scans the table: it skips entries shorter than a
// page, aligns each other entry to a page boundary and emits pages from it.
// A finished beat waits in the output register; the next command is accepted
// while it waits, but the sequencer stalls on a further beat until the
// receiver takes it. Reset empties the table (entry count and free byte total
// to zero) and drops any pending output beat. No clearing pass is needed.
module free_region_page_frame_allocator_unit
  import frpa_pkg::*;
#(
  parameter int unsigned MAX_REGIONS           = 32,
  parameter int unsigned MAX_PAGES_PER_REQUEST = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] region_base, [127:64] region_length, [191:128] virtual_base,
  // [198:192] page_count, [262:199] map_flags, [263] zero
  input  logic [263:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // [0] op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] virtual page, [127:64] physical_address, [191:128] flags_out
  output logic [191:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // [0] mapping_valid, [2:1] status
  output logic         m_axis_tlast
);

  localparam int unsigned IDX_W = $clog2(MAX_REGIONS > 1 ? MAX_REGIONS : 2);
  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);
  localparam logic [PAGE_CNT_W-1:0] MAX_PG = PAGE_CNT_W'(MAX_PAGES_PER_REQUEST);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_A_RD, S_A_CMP, S_M_TOT, S_M_RD, S_M_LD, S_M_AL, S_M_AL2,
    S_M_AL3, S_M_PG, S_M_EM, S_M_S1, S_M_S2, S_M_S3, S_M_S4
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [63:0]      total;
  logic [CNT_W-1:0] idx;
  logic [PAGE_CNT_W-1:0] done;
  logic [PAGE_CNT_W-1:0] pages;
  logic [63:0]      cur_start, cur_size, vaddr;
  logic [11:0]      lost;
  op_t              op;
  logic [63:0]      base, len, vbase, flags;
  logic [PAGE_CNT_W-1:0] pcnt;
  logic             res_pend;
  status_t          res_status;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  region_t  rd_entry, wr_entry;
  logic     ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic     out_free;
  logic     beat_load;

  frpa_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  frpa_ram #(.WIDTH($bits(region_t)), .DEPTH(MAX_REGIONS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign beat_load     = out_free && (res_pend || state == S_M_EM);

  always_comb begin
    alu_req = '{a: 64'd0, b: 64'd0, sub: 1'b0};
    unique case (state)
      S_DEC:   alu_req = '{a: total, b: len, sub: 1'b0};
      S_A_CMP: alu_req = '{a: rd_entry.start, b: base, sub: 1'b1};
      S_M_TOT: alu_req = '{a: total, b: 64'(pages) << PAGE_SHIFT, sub: 1'b1};
      S_M_LD:  alu_req = '{a: rd_entry.size, b: PAGE_BYTES, sub: 1'b1};
      S_M_AL:  alu_req = '{a: cur_start, b: 64'(lost), sub: 1'b0};
      S_M_AL2: alu_req = '{a: cur_size, b: 64'(lost), sub: 1'b1};
      S_M_AL3: alu_req = '{a: total, b: 64'(lost), sub: 1'b1};
      S_M_PG:  alu_req = '{a: cur_size, b: PAGE_BYTES, sub: 1'b1};
      S_M_S1:  alu_req = '{a: cur_start, b: PAGE_BYTES, sub: 1'b0};
      S_M_S2:  alu_req = '{a: cur_size, b: PAGE_BYTES, sub: 1'b1};
      S_M_S3:  alu_req = '{a: total, b: PAGE_BYTES, sub: 1'b1};
      S_M_S4:  alu_req = '{a: vaddr, b: PAGE_BYTES, sub: 1'b0};
      default: alu_req = '{a: 64'd0, b: 64'd0, sub: 1'b0};
    endcase
  end

  always_comb begin
    ram_raddr = idx[IDX_W-1:0];
    if (state == S_A_RD) begin
      ram_raddr = IDX_W'(idx - CNT_W'(1));
    end
    ram_we    = 1'b0;
    ram_waddr = idx[IDX_W-1:0];
    wr_entry  = '{start: base, size: len};
    // hold the table while a status beat waits for the output
    if (!res_pend && state == S_A_CMP) begin
      ram_we = 1'b1;
      if (alu_rsp.borrow) begin
        wr_entry = rd_entry;
      end
    end else if (!res_pend && state == S_A_RD && idx == '0) begin
      ram_we = 1'b1;
    end else if (state == S_M_PG && (alu_rsp.borrow || done == pages)) begin
      ram_we   = 1'b1;
      wr_entry = '{start: cur_start, size: cur_size};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      total         <= '0;
      res_pend      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (beat_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      // single status beat, issued from any state once the output is free
      if (res_pend && out_free) begin
        m_axis_tdata  <= '0;
        m_axis_tuser  <= {res_status, 1'b0};
        m_axis_tlast  <= 1'b1;
        res_pend      <= 1'b0;
        state         <= S_IDLE;
      end else if (!res_pend) begin
        unique case (state)
          S_IDLE: begin
            if (s_axis_tvalid) begin
              op    <= op_t'(s_axis_tuser);
              base  <= s_axis_tdata[63:0];
              len   <= s_axis_tdata[127:64];
              vbase <= s_axis_tdata[191:128];
              pcnt  <= s_axis_tdata[198:192];
              flags <= s_axis_tdata[262:199];
              state <= S_DEC;
            end
          end
          S_DEC: begin
            if (op == OP_ADD) begin
              if (count >= MAX_CNT) begin
                res_status <= ST_TABLE_FULL;
                res_pend   <= 1'b1;
              end else begin
                idx   <= count;
                count <= count + CNT_W'(1);
                total <= alu_rsp.y;
                state <= S_A_RD;
              end
            end else if (vbase[11:0] != 12'd0) begin
              res_status <= ST_MISALIGNED;
              res_pend   <= 1'b1;
            end else begin
              pages <= (pcnt > MAX_PG) ? MAX_PG : pcnt;
              state <= S_M_TOT;
            end
          end
          S_A_RD: begin
            if (idx == '0) begin
              res_status <= ST_OK;
              res_pend   <= 1'b1;
            end else begin
              state <= S_A_CMP;
            end
          end
          S_A_CMP: begin
            // shift the lower-based neighbor down one slot and keep walking up
            if (alu_rsp.borrow) begin
              idx   <= idx - CNT_W'(1);
              state <= S_A_RD;
            end else begin
              res_status <= ST_OK;
              res_pend   <= 1'b1;
            end
          end
          S_M_TOT: begin
            if (alu_rsp.borrow) begin
              res_status <= ST_NO_MEMORY;
              res_pend   <= 1'b1;
            end else begin
              idx   <= '0;
              done  <= '0;
              vaddr <= vbase;
              state <= S_M_RD;
            end
          end
          S_M_RD: begin
            if (idx == count) begin
              if (done != pages) begin
                res_status <= ST_NO_MEMORY;
                res_pend   <= 1'b1;
              end else if (done == '0) begin
                res_status <= ST_OK;
                res_pend   <= 1'b1;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              state <= S_M_LD;
            end
          end
          S_M_LD: begin
            cur_start <= rd_entry.start;
            cur_size  <= rd_entry.size;
            lost      <= 12'd0 - rd_entry.start[11:0];
            if (alu_rsp.borrow) begin
              idx   <= idx + CNT_W'(1);
              state <= S_M_RD;
            end else begin
              state <= S_M_AL;
            end
          end
          S_M_AL: begin
            cur_start <= alu_rsp.y;
            state     <= S_M_AL2;
          end
          S_M_AL2: begin
            cur_size <= alu_rsp.y;
            state    <= S_M_AL3;
          end
          S_M_AL3: begin
            total <= alu_rsp.y;
            state <= S_M_PG;
          end
          S_M_PG: begin
            if (alu_rsp.borrow || done == pages) begin
              idx   <= idx + CNT_W'(1);
              state <= S_M_RD;
            end else begin
              state <= S_M_EM;
            end
          end
          S_M_EM: begin
            if (out_free) begin
              m_axis_tdata  <= {flags, cur_start, vaddr};
              m_axis_tuser  <= {ST_OK, 1'b1};
              m_axis_tlast  <= (done + PAGE_CNT_W'(1) == pages);
              done          <= done + PAGE_CNT_W'(1);
              state         <= S_M_S1;
            end
          end
          S_M_S1: begin
            cur_start <= alu_rsp.y;
            state     <= S_M_S2;
          end
          S_M_S2: begin
            cur_size <= alu_rsp.y;
            state    <= S_M_S3;
          end
          S_M_S3: begin
            total <= alu_rsp.y;
            state <= S_M_S4;
          end
          S_M_S4: begin
            vaddr <= alu_rsp.y;
            state <= S_M_PG;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/frpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frpa_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/frpa_alu.sv
// Shared 64-bit add/subtract unit; borrow flags a < b on subtract.
module frpa_alu
  import frpa_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [64:0] sum;

  always_comb begin
    if (req.sub) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.y      = sum[63:0];
    rsp.borrow = req.sub & sum[64];
  end

endmodule

FILE: rtl/core/frpa_checker.sv
// Port-level checks for the page frame allocator, bound to the top level.
module frpa_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("status beat without tlast");

  a_map_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == 2'd0)
    else $error("mapping beat with error status");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind free_region_page_frame_allocator_unit frpa_checker u_frpa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
